/* rtl/dda_line_pixel_generator_macros.svh */
// Assertion macros for the DDA line pixel generator.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef DDA_LINE_PIXEL_GENERATOR_MACROS_SVH
`define DDA_LINE_PIXEL_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DLPG_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dlpg: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define DLPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dlpg: next-cycle check failed");

`endif

/* rtl/dlpg_pkg.sv */
// Shared types and constants for the DDA line pixel generator.
// No dependencies.
package dlpg_pkg;

   // field and port widths
   localparam int COORD_BITS_DEFAULT = 6;
   localparam int COORD_W            = 6;
   localparam int COLOR_W            = 8;
   localparam int ADDR_W             = 14;
   localparam int DIM_W              = 7;
   localparam int STRIDE_W           = 9;
   localparam int REQ_DATA_W         = 48;
   localparam int RSP_DATA_W         = 56;
   localparam int CSR_ADDR_W         = 3;
   localparam int CSR_DATA_W         = 32;

   // bytes per pixel and row alignment
   localparam int BYTES_PER_PIXEL    = 3;
   localparam int ROW_ALIGN          = 4;

   // register reset values
   localparam logic [DIM_W-1:0] CANVAS_WIDTH_RESET  = 7'd64;
   localparam logic [DIM_W-1:0] CANVAS_HEIGHT_RESET = 7'd64;

   // register index, taken from paddr bit 2
   localparam logic REG_CANVAS_WIDTH  = 1'b0;
   localparam logic REG_CANVAS_HEIGHT = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // padded row stride: width*3 rounded up to a multiple of 4
   function automatic logic [STRIDE_W-1:0] row_stride(input logic [DIM_W-1:0] width);
      logic [STRIDE_W-1:0] raw;
      raw = STRIDE_W'(width) * STRIDE_W'(BYTES_PER_PIXEL) + STRIDE_W'(ROW_ALIGN - 1);
      return raw & ~STRIDE_W'(ROW_ALIGN - 1);
   endfunction

endpackage

/* rtl/dda_line_pixel_generator.sv */
// Top level of the DDA line pixel generator: command intake, step sequencer,
// pixel output register and canvas registers. Depends on dlpg_pkg and the macros header.
//
// channel   direction  handshake          contents
// req_      in         tvalid/tready      one line command (endpoints, color)
// rsp_      out        tvalid/tready      one pixel write per item, tlast on the final one
// csr_      in         APB, pready high   canvas_width at 0x0, canvas_height at 0x4
//
// A command with d = max(|dx|,|dy|) first loads the step unit, then gives d+1
// pixel items, one per cycle without stalls, from a single shared
// accumulate/compare/step unit that advances once per delivered pixel.
// The block takes no new command until the last pixel of the current one is taken.
// A stalled pixel holds in the output register; the step unit waits with it.
// Reset is synchronous and returns the sequencer to idle, width and height to 64.
`include "dda_line_pixel_generator_macros.svh"

module dda_line_pixel_generator #(
   parameter int COORD_BITS = dlpg_pkg::COORD_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // command input
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // start_x, start_y, end_x, end_y, red, green, blue
   input  logic [dlpg_pkg::REQ_DATA_W-1:0]  req_tdata,
   // pixel output
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // pixel_x, pixel_y, byte_address, out_red, out_green, out_blue, zero pad
   output logic [dlpg_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // in_canvas
   output logic                             rsp_tuser,
   // last_pixel
   output logic                             rsp_tlast,
   // configuration
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [dlpg_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [dlpg_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [dlpg_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import dlpg_pkg::*;

   localparam int CB = COORD_BITS;

   // command fields, low COORD_BITS of each coordinate
   logic [CB-1:0]      x0, y0, x1, y1;
   logic [COLOR_W-1:0] red, green, blue;

   // sequencer and step unit state
   state_type          state_ff, state_in;
   logic [CB-1:0]      x_ff, x_in, y_ff, y_in;
   logic [CB:0]        ex_ff, ex_in, ey_ff, ey_in;
   logic [CB-1:0]      adx_ff, adx_in, ady_ff, ady_in;
   logic [CB-1:0]      d_ff, d_in;
   logic [CB-1:0]      cnt_ff, cnt_in;
   logic               xdown_ff, xdown_in, ydown_ff, ydown_in;
   logic [COLOR_W-1:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;

   // canvas registers
   logic [DIM_W-1:0]    width_ff, width_in, height_ff, height_in;
   logic [STRIDE_W-1:0] stride_ff, stride_in;

   // handshake and datapath helpers
   logic                req_fire, rsp_fire, csr_write;
   logic                cmd_xdown, cmd_ydown;
   logic [CB-1:0]       cmd_adx, cmd_ady;
   logic [CB:0]         ex_sum, ey_sum;
   logic [CB+1:0]       x_times3;
   logic [STRIDE_W+CB-1:0] row_offset;
   logic [ADDR_W-1:0]   byte_address;
   logic                in_canvas;

   assign x0    = req_tdata[CB-1:0];
   assign y0    = req_tdata[COORD_W+CB-1:COORD_W];
   assign x1    = req_tdata[2*COORD_W+CB-1:2*COORD_W];
   assign y1    = req_tdata[3*COORD_W+CB-1:3*COORD_W];
   assign red   = req_tdata[4*COORD_W+COLOR_W-1:4*COORD_W];
   assign green = req_tdata[4*COORD_W+2*COLOR_W-1:4*COORD_W+COLOR_W];
   assign blue  = req_tdata[4*COORD_W+3*COLOR_W-1:4*COORD_W+2*COLOR_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RUN);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   // command setup: direction and magnitudes
   assign cmd_xdown = (x1 < x0);
   assign cmd_ydown = (y1 < y0);
   assign cmd_adx   = cmd_xdown ? (x0 - x1) : (x1 - x0);
   assign cmd_ady   = cmd_ydown ? (y0 - y1) : (y1 - y0);

   // shared step unit: accumulate, compare against d
   assign ex_sum = ex_ff + (CB+1)'(adx_ff);
   assign ey_sum = ey_ff + (CB+1)'(ady_ff);

   // sequencer: next state and step unit update
   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      ex_in    = ex_ff;
      ey_in    = ey_ff;
      adx_in   = adx_ff;
      ady_in   = ady_ff;
      d_in     = d_ff;
      cnt_in   = cnt_ff;
      xdown_in = xdown_ff;
      ydown_in = ydown_ff;
      red_in   = red_ff;
      green_in = green_ff;
      blue_in  = blue_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_RUN;
               x_in     = x0;
               y_in     = y0;
               adx_in   = cmd_adx;
               ady_in   = cmd_ady;
               d_in     = (cmd_adx > cmd_ady) ? cmd_adx : cmd_ady;
               cnt_in   = (cmd_adx > cmd_ady) ? cmd_adx : cmd_ady;
               ex_in    = (CB+1)'(cmd_adx);
               ey_in    = (CB+1)'(cmd_ady);
               xdown_in = cmd_xdown;
               ydown_in = cmd_ydown;
               red_in   = red;
               green_in = green;
               blue_in  = blue;
            end
         end
         ST_RUN: begin
            if (rsp_fire) begin
               if (cnt_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff - CB'(1);
                  ex_in  = ex_sum;
                  ey_in  = ey_sum;
                  if (ex_sum > (CB+1)'(d_ff)) begin
                     ex_in = ex_sum - (CB+1)'(d_ff);
                     x_in  = xdown_ff ? (x_ff - CB'(1)) : (x_ff + CB'(1));
                  end
                  if (ey_sum > (CB+1)'(d_ff)) begin
                     ey_in = ey_sum - (CB+1)'(d_ff);
                     y_in  = ydown_ff ? (y_ff - CB'(1)) : (y_ff + CB'(1));
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // step unit payload, no reset needed
   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      ex_ff    <= ex_in;
      ey_ff    <= ey_in;
      adx_ff   <= adx_in;
      ady_ff   <= ady_in;
      d_ff     <= d_in;
      cnt_ff   <= cnt_in;
      xdown_ff <= xdown_in;
      ydown_ff <= ydown_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   // configuration registers; stride kept precomputed
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      stride_in = stride_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_CANVAS_WIDTH: begin
               width_in  = csr_pwdata[DIM_W-1:0];
               stride_in = row_stride(csr_pwdata[DIM_W-1:0]);
            end
            REG_CANVAS_HEIGHT: height_in = csr_pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CANVAS_WIDTH_RESET;
         height_ff <= CANVAS_HEIGHT_RESET;
         stride_ff <= row_stride(CANVAS_WIDTH_RESET);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         stride_ff <= stride_in;
      end
   end

   // register readback
   always_comb begin
      unique case (csr_paddr[2])
         REG_CANVAS_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_CANVAS_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // pixel address and bounds from the held position
   assign x_times3     = (CB+2)'({x_ff, 1'b0}) + (CB+2)'(x_ff);
   assign row_offset   = (STRIDE_W+CB)'(stride_ff) * (STRIDE_W+CB)'(y_ff);
   assign byte_address = ADDR_W'(x_times3) + ADDR_W'(row_offset);
   assign in_canvas    = (DIM_W'(x_ff) < width_ff) && (DIM_W'(y_ff) < height_ff);

   assign rsp_tdata = {(RSP_DATA_W - 2*COORD_W - ADDR_W - 3*COLOR_W)'(0),
                       blue_ff, green_ff, red_ff, byte_address,
                       COORD_W'(y_ff), COORD_W'(x_ff)};
   assign rsp_tuser = in_canvas;
   assign rsp_tlast = (cnt_ff == '0);

   // checks
   `DLPG_ASSERT_IMPL(a_no_intake_while_busy, clock, reset, rsp_tvalid, !req_tready)
   `DLPG_ASSERT_NEXT(a_first_pixel_is_start, clock, reset, req_fire,
                     rsp_tvalid && x_ff == $past(x0) && y_ff == $past(y0))
   `DLPG_ASSERT_NEXT(a_last_ends_command, clock, reset, rsp_fire && rsp_tlast, req_tready)
   `DLPG_ASSERT_IMPL(a_err_bounded, clock, reset, rsp_tvalid,
                     ex_ff <= (CB+1)'(d_ff) && ey_ff <= (CB+1)'(d_ff))
   `DLPG_ASSERT_IMPL(a_count_bounded, clock, reset, rsp_tvalid, cnt_ff <= d_ff)

endmodule

/* tb/sv/dda_line_pixel_generator_checker.sv */
// Scoreboard for the DDA line pixel generator: tracks canvas register writes,
// expands every accepted line command into its pixel writes and checks the output.
// Depends on dlpg_pkg.
module dda_line_pixel_generator_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [dlpg_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [dlpg_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             rsp_tuser,
   input  logic                             rsp_tlast,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [dlpg_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [dlpg_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input  logic                             csr_pready,
   output int                               fail_count,
   output int                               pending_pixels
);
   import dlpg_pkg::*;

   // field positions in rsp_tdata, lowest first
   localparam int ADDR_LSB  = 2 * COORD_W;
   localparam int RED_LSB   = ADDR_LSB + ADDR_W;
   localparam int GREEN_LSB = RED_LSB + COLOR_W;
   localparam int BLUE_LSB  = GREEN_LSB + COLOR_W;

   typedef struct {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [ADDR_W-1:0]  byte_address;
      logic               in_canvas;
      logic [COLOR_W-1:0] out_red;
      logic [COLOR_W-1:0] out_green;
      logic [COLOR_W-1:0] out_blue;
      logic               last_pixel;
   } pixel_write_type;

   pixel_write_type  expected_pixels[$];
   logic [DIM_W-1:0] canvas_width  = CANVAS_WIDTH_RESET;
   logic [DIM_W-1:0] canvas_height = CANVAS_HEIGHT_RESET;
   int               failures = 0;
   int               pending  = 0;

   assign fail_count     = failures;
   assign pending_pixels = pending;

   function automatic void check_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         failures++;
      end
   endfunction

   // step the line with the two error accumulators, queue one write per pixel
   task automatic trace_line(input logic [REQ_DATA_W-1:0] cmd);
      logic [COORD_W-1:0] x, y, x_end, y_end;
      logic [COLOR_W-1:0] red, green, blue;
      logic               x_down, y_down;
      int                 adx, ady, span, err_x, err_y, stride, step;
      pixel_write_type    px;
      x      = cmd[0 +: COORD_W];
      y      = cmd[COORD_W +: COORD_W];
      x_end  = cmd[2*COORD_W +: COORD_W];
      y_end  = cmd[3*COORD_W +: COORD_W];
      red    = cmd[4*COORD_W +: COLOR_W];
      green  = cmd[4*COORD_W+COLOR_W +: COLOR_W];
      blue   = cmd[4*COORD_W+2*COLOR_W +: COLOR_W];
      x_down = x_end < x;
      y_down = y_end < y;
      adx    = x_down ? int'(x) - int'(x_end) : int'(x_end) - int'(x);
      ady    = y_down ? int'(y) - int'(y_end) : int'(y_end) - int'(y);
      span   = (adx > ady) ? adx : ady;
      err_x  = adx;
      err_y  = ady;
      // row pitch padded to a 4-byte boundary
      stride = (int'(canvas_width) * BYTES_PER_PIXEL + ROW_ALIGN - 1) & ~(ROW_ALIGN - 1);
      for (step = 0; step <= span; step++) begin
         if (step > 0) begin
            err_x += adx;
            err_y += ady;
            if (err_x > span) begin
               err_x -= span;
               x = x_down ? x - COORD_W'(1) : x + COORD_W'(1);
            end
            if (err_y > span) begin
               err_y -= span;
               y = y_down ? y - COORD_W'(1) : y + COORD_W'(1);
            end
         end
         px.pixel_x      = x;
         px.pixel_y      = y;
         px.byte_address = ADDR_W'(int'(x) * BYTES_PER_PIXEL + stride * int'(y));
         px.in_canvas    = (DIM_W'(x) < canvas_width) && (DIM_W'(y) < canvas_height);
         px.out_red      = red;
         px.out_green    = green;
         px.out_blue     = blue;
         px.last_pixel   = (step == span);
         expected_pixels.push_back(px);
      end
   endtask

   // all channels sampled at the rising edge, before the block updates
   always @(posedge clock) begin
      pixel_write_type head;
      if (reset) begin
         canvas_width  = CANVAS_WIDTH_RESET;
         canvas_height = CANVAS_HEIGHT_RESET;
         expected_pixels.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_CANVAS_WIDTH)
               canvas_width = csr_pwdata[DIM_W-1:0];
            else
               canvas_height = csr_pwdata[DIM_W-1:0];
         end
         if (req_tvalid && req_tready)
            trace_line(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               $error("pixel write at (%0d,%0d) with no line command pending",
                      rsp_tdata[0 +: COORD_W], rsp_tdata[COORD_W +: COORD_W]);
               failures++;
            end else begin
               head = expected_pixels.pop_front();
               check_field("pixel_x", head.pixel_x, rsp_tdata[0 +: COORD_W]);
               check_field("pixel_y", head.pixel_y, rsp_tdata[COORD_W +: COORD_W]);
               check_field("byte_address", head.byte_address, rsp_tdata[ADDR_LSB +: ADDR_W]);
               check_field("in_canvas", head.in_canvas, rsp_tuser);
               check_field("out_red", head.out_red, rsp_tdata[RED_LSB +: COLOR_W]);
               check_field("out_green", head.out_green, rsp_tdata[GREEN_LSB +: COLOR_W]);
               check_field("out_blue", head.out_blue, rsp_tdata[BLUE_LSB +: COLOR_W]);
               check_field("last_pixel", head.last_pixel, rsp_tlast);
            end
         end
      end
      pending <= expected_pixels.size();
   end

endmodule

/* tb/sv/dda_line_pixel_generator_tb.sv */
// Testbench top for the DDA line pixel generator: clock, reset, line commands,
// canvas register writes and output back-pressure; checking is in the checker module.
// Depends on dlpg_pkg, dda_line_pixel_generator and dda_line_pixel_generator_checker.
module dda_line_pixel_generator_tb;
   import dlpg_pkg::*;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   // start_x, start_y, end_x, end_y, red, green, blue
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   // pixel_x, pixel_y, byte_address, out_red, out_green, out_blue, zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // in_canvas
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int send_idle_pct = 13;
   int recv_idle_pct = 51;
   int check_failures;
   int pixels_pending;

   dda_line_pixel_generator uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   dda_line_pixel_generator_checker scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .fail_count     (check_failures),
      .pending_pixels (pixels_pending)
   );

   always #1 clock = ~clock;

   // random back-pressure on the pixel stream
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // color is {blue, green, red}; valid stays high into the next item unless a gap is taken
   task automatic send_line(input int sx, sy, ex, ey, input int unsigned color);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {(3*COLOR_W)'(color), COORD_W'(ey), COORD_W'(ex),
                     COORD_W'(sy), COORD_W'(sx)};
      do @(posedge clock); while (!req_tready);
   endtask

   // hold off commands until every pixel write has come back
   task automatic drain_pixels();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pixels_pending == 0);
      repeat (4) @(posedge clock);
   endtask

   // upper data bits are random; only the low register bits should stick
   task automatic write_csr(input logic reg_index, input int value);
      logic [CSR_DATA_W-1:0] data;
      data             = $urandom();
      data[DIM_W-1:0]  = DIM_W'(value);
      drain_pixels();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_canvas(input int w, input int h);
      write_csr(REG_CANVAS_WIDTH, w);
      write_csr(REG_CANVAS_HEIGHT, h);
   endtask

   // mostly free lines, with some zero-length, axis-aligned and corner-to-corner ones
   task automatic send_random_line();
      int sx, sy, ex, ey;
      sx = $urandom_range(63);
      sy = $urandom_range(63);
      ex = $urandom_range(63);
      ey = $urandom_range(63);
      case ($urandom_range(9))
         0: begin
            ex = sx;
            ey = sy;
         end
         1: ey = sy;
         2: ex = sx;
         3: begin
            sx = (sx & 1) ? 63 : 0;
            sy = (sy & 1) ? 63 : 0;
            ex = (ex & 1) ? 63 : 0;
            ey = (ey & 1) ? 63 : 0;
         end
         default: ;
      endcase
      send_line(sx, sy, ex, ey, $urandom());
   endtask

   initial begin
      int phase, blk, n;
      int w, h;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset canvas of 64 by 64: dots, full-length axis lines, diagonals, steep/shallow
      send_line(0, 0, 0, 0, 24'h000000);
      send_line(63, 63, 63, 63, 24'hFFFFFF);
      send_line(0, 0, 63, 0, 24'h0000FF);
      send_line(63, 5, 0, 5, 24'h00FF00);
      send_line(7, 0, 7, 63, 24'hFF0000);
      send_line(9, 63, 9, 0, 24'hA5A5A5);
      send_line(0, 0, 63, 63, 24'h5A5A5A);
      send_line(63, 0, 0, 63, $urandom());
      send_line(2, 3, 12, 40, $urandom());
      send_line(50, 40, 3, 31, $urandom());
      send_line(0, 63, 1, 0, $urandom());
      send_line(10, 10, 11, 11, $urandom());

      // small canvas: lines leaving it on the right and bottom, a dot outside
      set_canvas(20, 10);
      send_line(15, 5, 30, 5, $urandom());
      send_line(5, 2, 5, 20, $urandom());
      send_line(25, 15, 25, 15, $urandom());
      send_line(19, 9, 20, 10, $urandom());

      // zero-size canvas: nothing is inside
      set_canvas(0, 0);
      send_line(0, 0, 3, 2, $urandom());

      // widest register value: stride above 64 pixels, address wraps at 14 bits
      set_canvas(127, 127);
      send_line(63, 63, 0, 0, $urandom());
      send_line(40, 60, 63, 62, $urandom());

      set_canvas(1, 1);
      send_line(0, 0, 2, 1, $urandom());
      set_canvas(64, 1);
      send_line(0, 0, 1, 5, $urandom());

      // random lines in three back-pressure regimes, new canvas every block
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 51 : 0;
         recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 13 : 0;
         for (blk = 0; blk < 3; blk++) begin
            w = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(1, 64);
            h = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(1, 64);
            set_canvas(w, h);
            for (n = 0; n < 15; n++)
               send_random_line();
         end
      end

      drain_pixels();
      repeat (20) @(posedge clock);
      if (check_failures == 0 && pixels_pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // watchdog
   initial begin
      #1000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
